### rtl/tsfr_pkg.sv
package tsfr_pkg;

  // Line tags in bits 7..6 of a received byte
  localparam logic [1:0] TAG_CMD = 2'b00;
  localparam logic [1:0] TAG_A   = 2'b01;
  localparam logic [1:0] TAG_B   = 2'b10;
  localparam logic [1:0] TAG_END = 2'b11;

  // Command codes
  localparam logic [5:0] CMD_NONE      = 6'h00;
  localparam logic [5:0] CMD_ACK0      = 6'h20;
  localparam logic [5:0] CMD_PING      = 6'h21;
  localparam logic [5:0] CMD_PEER_ACK  = 6'h22;
  localparam logic [5:0] CMD_STATUS    = 6'h23;
  localparam logic [5:0] CMD_ACK1      = 6'h24;
  localparam logic [5:0] CMD_ACK2      = 6'h25;
  localparam logic [5:0] CMD_PEER_NACK = 6'h2E;
  localparam logic [5:0] CMD_RESET     = 6'h2F;

  // Reset command key bytes
  localparam logic [7:0] KEY_A = 8'h4D;
  localparam logic [7:0] KEY_B = 8'h1E;

  // Transmitted bytes
  localparam logic [7:0] BYTE_PING   = 8'h01;
  localparam logic [7:0] BYTE_ACK    = 8'h02;
  localparam logic [7:0] BYTE_STATUS = 8'h03;
  localparam logic [7:0] BYTE_NACK   = 8'h0E;
  localparam logic [7:0] BYTE_END    = 8'hC0;
  localparam logic [7:0] BYTE_DATA   = 8'h80;

  // Result kinds
  localparam logic [1:0] KIND_TX        = 2'd0;
  localparam logic [1:0] KIND_PEER_ACK  = 2'd1;
  localparam logic [1:0] KIND_PEER_NACK = 2'd2;

  localparam logic [63:0] STATUS_RESET = 64'h0000_32D2_32FD_D721;

  // Job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    JOB_ACK       = 3'd0,
    JOB_PING      = 3'd1,
    JOB_PEER_ACK  = 3'd2,
    JOB_PEER_NACK = 3'd3,
    JOB_STATUS    = 3'd4,
    JOB_RST_OK    = 3'd5,
    JOB_RST_BAD   = 3'd6
  } job_kind_t;

  typedef struct packed {
    logic      valid;
    job_kind_t kind;
  } job_push_t;

  typedef struct packed {
    logic      avail;
    job_kind_t kind;
  } job_head_t;

endpackage

### rtl/tsfr_front.sv
module tsfr_front import tsfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_rx_byte,
  output logic       in_stall,
  input  logic       q_full,
  output job_push_t  push
);

  logic [5:0] cmd_r, cmd_nxt;
  logic [1:0] a_cnt_r, a_cnt_nxt, b_cnt_r, b_cnt_nxt;
  logic [5:0] a0_r, a0_nxt, a1_r, a1_nxt, b0_r, b0_nxt, b1_r, b1_nxt;
  logic       accept;
  logic [1:0] tag;
  logic [5:0] data;
  logic [5:0] a0_eff, a1_eff, b0_eff, b1_eff;
  logic [7:0] first_a, first_b;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign tag      = in_rx_byte[7:6];
  assign data     = in_rx_byte[5:0];

  // Missing sextets read as zero
  assign a0_eff  = (a_cnt_r > 2'd0) ? a0_r : 6'd0;
  assign a1_eff  = (a_cnt_r > 2'd1) ? a1_r : 6'd0;
  assign b0_eff  = (b_cnt_r > 2'd0) ? b0_r : 6'd0;
  assign b1_eff  = (b_cnt_r > 2'd1) ? b1_r : 6'd0;
  assign first_a = {a0_eff, a1_eff[5:4]};
  assign first_b = {b0_eff, b1_eff[5:4]};

  always_comb begin
    cmd_nxt    = cmd_r;
    a_cnt_nxt  = a_cnt_r;
    b_cnt_nxt  = b_cnt_r;
    a0_nxt     = a0_r;
    a1_nxt     = a1_r;
    b0_nxt     = b0_r;
    b1_nxt     = b1_r;
    push.valid = 1'b0;
    push.kind  = JOB_ACK;
    if (accept) begin
      case (tag)
        TAG_CMD: begin
          cmd_nxt = data;
        end
        TAG_A: begin
          if (cmd_r != CMD_NONE && a_cnt_r < 2'd2) begin
            if (a_cnt_r == 2'd0) a0_nxt = data;
            else a1_nxt = data;
            a_cnt_nxt = a_cnt_r + 2'd1;
          end
        end
        TAG_B: begin
          if (cmd_r != CMD_NONE && b_cnt_r < 2'd2) begin
            if (b_cnt_r == 2'd0) b0_nxt = data;
            else b1_nxt = data;
            b_cnt_nxt = b_cnt_r + 2'd1;
          end
        end
        TAG_END: begin
          if (cmd_r != CMD_NONE) begin
            push.valid = 1'b1;
            case (cmd_r)
              CMD_ACK0, CMD_ACK1, CMD_ACK2: push.kind = JOB_ACK;
              CMD_PING:      push.kind = JOB_PING;
              CMD_PEER_ACK:  push.kind = JOB_PEER_ACK;
              CMD_PEER_NACK: push.kind = JOB_PEER_NACK;
              CMD_STATUS:    push.kind = JOB_STATUS;
              CMD_RESET: begin
                push.kind = (first_a == KEY_A && first_b == KEY_B) ? JOB_RST_OK
                                                                   : JOB_RST_BAD;
              end
              default: push.valid = 1'b0;
            endcase
            // Close the frame
            cmd_nxt   = CMD_NONE;
            a_cnt_nxt = 2'd0;
            b_cnt_nxt = 2'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= CMD_NONE;
      a_cnt_r <= 2'd0;
      b_cnt_r <= 2'd0;
      a0_r    <= 6'd0;
      a1_r    <= 6'd0;
      b0_r    <= 6'd0;
      b1_r    <= 6'd0;
    end else begin
      cmd_r   <= cmd_nxt;
      a_cnt_r <= a_cnt_nxt;
      b_cnt_r <= b_cnt_nxt;
      a0_r    <= a0_nxt;
      a1_r    <= a1_nxt;
      b0_r    <= b0_nxt;
      b1_r    <= b1_nxt;
    end
  end

endmodule

### rtl/tsfr_queue.sv
module tsfr_queue import tsfr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  job_push_t push,
  output logic      full,
  input  logic      pop,
  output job_head_t head
);

  job_kind_t       mem_r [QDEPTH];
  logic [QAW-1:0]  wptr_r, rptr_r;
  logic [QAW:0]    cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full      = (cnt_r == (QAW+1)'(QDEPTH));
  assign head.avail = (cnt_r != '0);
  assign head.kind  = mem_r[rptr_r];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && head.avail;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push.kind;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop) rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/tsfr_back.sv
module tsfr_back import tsfr_pkg::*; #(
  parameter int STATUS_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  job_head_t   head,
  output logic        pop,
  input  logic [63:0] status_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_reset_request,
  output logic        out_last
);

  localparam int NSX = (8 * STATUS_BYTES + 5) / 6;
  localparam int SW  = $clog2(NSX + 2);
  localparam logic [63:0] KEEP_MASK = ~(64'hFFFF_FFFF_FFFF_FFFF >> (8 * STATUS_BYTES));

  logic        active_r;
  job_kind_t   job_r;
  logic [SW-1:0] step_r;
  logic [65:0] sh_r;

  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [7:0]  byte_r;
  logic        rst_req_r;
  logic        last_r;

  logic        out_free, emit;
  logic [1:0]  r_kind;
  logic [7:0]  r_byte;
  logic        r_rst, r_last;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = active_r && out_free;
  assign pop      = head.avail && (!active_r || (emit && r_last));

  // Result for the current job and step
  always_comb begin
    r_kind = KIND_TX;
    r_byte = 8'd0;
    r_rst  = 1'b0;
    r_last = 1'b0;
    case (job_r)
      JOB_PEER_ACK: begin
        r_kind = KIND_PEER_ACK;
        r_last = 1'b1;
      end
      JOB_PEER_NACK: begin
        r_kind = KIND_PEER_NACK;
        r_last = 1'b1;
      end
      JOB_STATUS: begin
        if (step_r == '0) r_byte = BYTE_STATUS;
        else if (step_r == SW'(NSX + 1)) begin
          r_byte = BYTE_END;
          r_last = 1'b1;
        end else r_byte = BYTE_DATA | {2'b00, sh_r[65:60]};
      end
      JOB_ACK, JOB_PING, JOB_RST_OK, JOB_RST_BAD: begin
        if (step_r == '0) begin
          case (job_r)
            JOB_PING:    r_byte = BYTE_PING;
            JOB_RST_BAD: r_byte = BYTE_NACK;
            default:     r_byte = BYTE_ACK;
          endcase
        end else begin
          r_byte = BYTE_END;
          r_last = 1'b1;
          r_rst  = (job_r == JOB_RST_OK);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (pop) begin
        active_r <= 1'b1;
        step_r   <= '0;
      end else if (emit) begin
        if (r_last) active_r <= 1'b0;
        step_r <= step_r + 1'b1;
      end
      if (out_free) out_valid_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= head.kind;
      sh_r  <= {status_payload & KEEP_MASK, 2'b00};
    end else if (emit && job_r == JOB_STATUS && step_r != '0) begin
      sh_r <= sh_r << 6;
    end
    if (emit) begin
      kind_r    <= r_kind;
      byte_r    <= r_byte;
      rst_req_r <= r_rst;
      last_r    <= r_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_tx_byte       = byte_r;
  assign out_reset_request = rst_req_r;
  assign out_last          = last_r;

endmodule

### rtl/tagged_sextet_frame_responder.sv
// Tagged sextet frame responder.
// Input channel: one received line byte per beat (in_valid / in_stall), bits 7..6
// tag, bits 5..0 sextet. Tag 00 loads the command, 01 and 10 add channel A / B
// sextets, 11 closes the frame and triggers the response for the command.
// Output channel (out_valid / out_stall): one result beat per cycle unless
// stalled, carrying out_kind, out_tx_byte, out_reset_request and out_last; the
// out_last flag marks the final beat caused by one input byte.
// Config channel: cfg_valid / cfg_ready writes status_payload; cfg_ready is
// always high. Write only while the block is idle.
// Throughput: one input byte per cycle unless stalled; one result beat per cycle
// unless stalled. A status response is 2 + ceil(8*STATUS_BYTES/6) beats.
// The first result of a frame follows its accepted end byte through the job
// queue write, the job register load, then the output register load.
// A four-entry job queue sits between the frame decoder and the response
// sequencer; in_stall rises only when that queue is full.
// Reset (rst_n, synchronous) clears the command, sextet counts, queue and
// output valid, and loads the default status payload.
// While out_stall is high on a valid beat, that beat holds and the sequencer waits.
module tagged_sextet_frame_responder import tsfr_pkg::*; #(
  parameter int STATUS_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_reset_request,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_status_payload
);

  logic [63:0] status_r;
  job_push_t   push;
  job_head_t   head;
  logic        q_full;
  logic        pop;

  // Config register: always ready, take the beat directly
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= STATUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      status_r <= cfg_status_payload;
    end
  end

  // Front: decode frames, classify the response
  tsfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .push       (push)
  );

  // Hold pending responses so each side can stall alone
  tsfr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .head  (head)
  );

  // Back: advance through the beats of each response
  tsfr_back #(
    .STATUS_BYTES (STATUS_BYTES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .pop               (pop),
    .status_payload    (status_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_tx_byte       (out_tx_byte),
    .out_reset_request (out_reset_request),
    .out_last          (out_last)
  );

  // A reset request only rides on the closing C0 of an ACK
  a_rst_req_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reset_request |-> out_last && out_tx_byte == BYTE_END)
    else $error("reset request on a beat other than the closing byte");

  // Peer reports carry no byte and are single-beat responses
  a_peer_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_TX |-> out_tx_byte == 8'd0 && out_last)
    else $error("peer report beat carries a byte or is not last");

  // Input stalls only while the job queue is full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_full)
    else $error("input stalled with room in the job queue");

  // Output empties after reset
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule
